// ===== rtl/lfpd_pkg.sv =====
// types and constants shared by the packet deframer files
package lfpd_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [1:0]  kind_t;
  typedef logic [15:0] id_t;

  // input command codes
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // result kinds
  localparam kind_t KIND_BYTE  = 2'd0;
  localparam kind_t KIND_ID    = 2'd1;
  localparam kind_t KIND_ERROR = 2'd2;

  // packet command codes
  localparam byte_t PKT_CMD_ID  = 8'h01;
  localparam byte_t PKT_CMD_FWD = 8'h02;

  localparam byte_t CHAR_CR = 8'h0D;
  localparam byte_t CHAR_LF = 8'h0A;

  // shortest legal length field (command plus checksum)
  localparam byte_t MIN_LEN = 8'd2;

  // configuration registers
  localparam int    CFG_IDX_W   = 2;
  localparam int    CFG_W       = 8;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRAILER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;

  localparam byte_t RST_HEADER  = 8'hAA;
  localparam byte_t RST_TRAILER = 8'hBB;
  localparam byte_t RST_TIMEOUT = 8'd20;

  typedef struct packed {
    kind_t kind;
    byte_t data_byte;
    id_t   vendor_id;
    id_t   product_id;
    logic  last;
  } result_t;

endpackage

// ===== rtl/lfpd_if.sv =====
// valid/ready channel interfaces for input items and results
interface lfpd_in_if import lfpd_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  command;
  byte_t rx_byte;

  modport source (output valid, command, rx_byte, input ready);
  modport sink   (input valid, command, rx_byte, output ready);
endinterface

interface lfpd_out_if import lfpd_pkg::*; ();
  logic  valid;
  logic  ready;
  kind_t kind;
  byte_t data_byte;
  id_t   vendor_id;
  id_t   product_id;
  logic  last;

  modport source (output valid, kind, data_byte, vendor_id, product_id, last, input ready);
  modport sink   (input valid, kind, data_byte, vendor_id, product_id, last, output ready);
endinterface

// ===== rtl/lfpd_out_stage.sv =====
// output register stage that holds one result until the sink takes it
module lfpd_out_stage import lfpd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  output logic    slot_free,
  lfpd_out_if.source result_out
);

  logic    valid;
  result_t held;

  assign slot_free = !valid || result_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (result_out.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign result_out.valid      = valid;
  assign result_out.kind       = held.kind;
  assign result_out.data_byte  = held.data_byte;
  assign result_out.vendor_id  = held.vendor_id;
  assign result_out.product_id = held.product_id;
  assign result_out.last       = held.last;

endmodule

// ===== rtl/length_framed_packet_deframer_unit.sv =====
// Packet deframer: bytes and timer ticks come in on item_in, one per transaction. A packet is
// a header byte, a length L (at least 2), L bytes (command, data, checksum) and a trailer byte,
// all kept in a BUF_DEPTH-byte buffer with one write and one registered read port. An item is
// taken whenever the result sequencer is idle; the final result of a packet may still be waiting
// in the output register at that point. A dropped packet gives one error result through the
// S_ERR state; command 1 gives an id report after four buffer reads; command 2 forwards the
// L-2 data bytes, each read from the registered buffer port in S_FRD and sent in S_FOUT, and
// then CR and LF. A stalled sink holds back each of these results.
module length_framed_packet_deframer_unit import lfpd_pkg::*; #(
  parameter int BUF_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  lfpd_in_if.sink              item_in,
  lfpd_out_if.source           result_out
);

  localparam int AW    = $clog2(BUF_DEPTH);
  localparam int IDX_W = $clog2(BUF_DEPTH + 1);
  localparam int CW    = (IDX_W > 9) ? IDX_W : 9;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_LENGTH  = 2'd1;
  localparam logic [1:0] PH_BODY    = 2'd2;
  localparam logic [1:0] PH_TRAILER = 2'd3;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ERR   = 3'd1;
  localparam logic [2:0] S_ID    = 3'd2;
  localparam logic [2:0] S_IDOUT = 3'd3;
  localparam logic [2:0] S_FRD   = 3'd4;
  localparam logic [2:0] S_FOUT  = 3'd5;
  localparam logic [2:0] S_CR    = 3'd6;
  localparam logic [2:0] S_LF    = 3'd7;

  localparam logic [2:0] ID_READS = 3'd4;

  // configuration
  byte_t header_byte;
  byte_t trailer_byte;
  byte_t timeout_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte   <= RST_HEADER;
      trailer_byte  <= RST_TRAILER;
      timeout_ticks <= RST_TIMEOUT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEADER:  header_byte   <= cfg_data;
        REG_TRAILER: trailer_byte  <= cfg_data;
        REG_TIMEOUT: timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // parser state
  logic [1:0]       phase, phase_next;
  logic [IDX_W-1:0] byte_index, byte_index_next;
  byte_t            pkt_len, pkt_len_next;
  byte_t            pkt_cmd, pkt_cmd_next;
  byte_t            timeout_left, timeout_left_next;
  logic             packet_open, packet_open_next;

  // sequencer state
  logic [2:0]       state, state_next;
  logic [2:0]       rd_cnt;
  logic [31:0]      id_word;
  logic [IDX_W-1:0] fwd_ptr;

  // packet buffer
  byte_t            pkt_mem [BUF_DEPTH];
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  byte_t            mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  byte_t            mem_rdata;

  logic             in_fire;
  logic             buf_full;
  logic [1:0]       eff_phase;
  logic             ev_error;
  logic             ev_finish;

  logic             res_load;
  result_t          res;
  logic             slot_free;

  assign item_in.ready = (state == S_IDLE);
  assign in_fire       = item_in.valid && item_in.ready;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pkt_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= pkt_mem[mem_raddr];
    end
  end

  always_comb begin
    phase_next        = phase;
    byte_index_next   = byte_index;
    pkt_len_next      = pkt_len;
    pkt_cmd_next      = pkt_cmd;
    timeout_left_next = timeout_left;
    packet_open_next  = packet_open;
    mem_we            = 1'b0;
    mem_waddr         = byte_index[AW-1:0];
    mem_wdata         = item_in.rx_byte;
    ev_error          = 1'b0;
    ev_finish         = 1'b0;
    buf_full  = ((phase == PH_BODY) || (phase == PH_TRAILER)) &&
                (byte_index >= IDX_W'(BUF_DEPTH));
    eff_phase = buf_full ? PH_HEADER : phase;
    if (in_fire) begin
      if (item_in.command == CMD_TICK) begin
        if (packet_open) begin
          if (timeout_left <= 8'd1) begin
            ev_error          = 1'b1;
            phase_next        = PH_HEADER;
            byte_index_next   = '0;
            timeout_left_next = '0;
            packet_open_next  = 1'b0;
          end else begin
            timeout_left_next = timeout_left - 8'd1;
          end
        end
      end else begin
        if (buf_full) begin
          ev_error          = 1'b1;
          phase_next        = PH_HEADER;
          byte_index_next   = '0;
          timeout_left_next = '0;
          packet_open_next  = 1'b0;
        end
        case (eff_phase)
          PH_HEADER: begin
            // a full buffer drop still lets this byte open a new packet
            if (item_in.rx_byte == header_byte) begin
              mem_we            = 1'b1;
              mem_waddr         = '0;
              byte_index_next   = IDX_W'(1);
              phase_next        = PH_LENGTH;
              packet_open_next  = 1'b1;
              timeout_left_next = timeout_ticks;
            end
          end
          PH_LENGTH: begin
            mem_we       = 1'b1;
            mem_waddr    = AW'(1);
            pkt_len_next = item_in.rx_byte;
            if (item_in.rx_byte < MIN_LEN) begin
              ev_error          = 1'b1;
              phase_next        = PH_HEADER;
              byte_index_next   = '0;
              timeout_left_next = '0;
              packet_open_next  = 1'b0;
            end else begin
              byte_index_next = IDX_W'(2);
              phase_next      = PH_BODY;
            end
          end
          PH_BODY: begin
            mem_we          = 1'b1;
            byte_index_next = byte_index + IDX_W'(1);
            if (byte_index == IDX_W'(2)) begin
              pkt_cmd_next = item_in.rx_byte;
            end
            // next index reaches L+2, the trailer position
            if (CW'(byte_index) == CW'(pkt_len) + CW'(1)) begin
              phase_next = PH_TRAILER;
            end
          end
          default: begin
            mem_we            = 1'b1;
            phase_next        = PH_HEADER;
            byte_index_next   = '0;
            timeout_left_next = '0;
            packet_open_next  = 1'b0;
            if (item_in.rx_byte == trailer_byte) begin
              ev_finish = 1'b1;
            end else begin
              ev_error = 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      byte_index   <= '0;
      timeout_left <= '0;
      packet_open  <= 1'b0;
    end else begin
      phase        <= phase_next;
      byte_index   <= byte_index_next;
      timeout_left <= timeout_left_next;
      packet_open  <= packet_open_next;
    end
  end

  always_ff @(posedge clk) begin
    pkt_len <= pkt_len_next;
    pkt_cmd <= pkt_cmd_next;
  end

  // result sequencer
  always_comb begin
    state_next = state;
    mem_re     = 1'b0;
    mem_raddr  = fwd_ptr[AW-1:0];
    res_load   = 1'b0;
    res        = '0;
    case (state)
      S_IDLE: begin
        if (ev_error) begin
          state_next = S_ERR;
        end else if (ev_finish) begin
          if (pkt_cmd == PKT_CMD_ID) begin
            state_next = S_ID;
          end else if (pkt_cmd == PKT_CMD_FWD) begin
            state_next = (pkt_len == MIN_LEN) ? S_CR : S_FRD;
          end
        end
      end
      S_ERR: begin
        if (slot_free) begin
          res_load   = 1'b1;
          res.kind   = KIND_ERROR;
          res.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_ID: begin
        if (rd_cnt != ID_READS) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(3) + AW'(rd_cnt);
        end else begin
          state_next = S_IDOUT;
        end
      end
      S_IDOUT: begin
        if (slot_free) begin
          res_load       = 1'b1;
          res.kind       = KIND_ID;
          res.vendor_id  = id_word[15:0];
          res.product_id = id_word[31:16];
          res.last       = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_FRD: begin
        mem_re     = 1'b1;
        state_next = S_FOUT;
      end
      S_FOUT: begin
        if (slot_free) begin
          res_load      = 1'b1;
          res.kind      = KIND_BYTE;
          res.data_byte = mem_rdata;
          state_next    = (CW'(fwd_ptr) == CW'(pkt_len)) ? S_CR : S_FRD;
        end
      end
      S_CR: begin
        if (slot_free) begin
          res_load      = 1'b1;
          res.kind      = KIND_BYTE;
          res.data_byte = CHAR_CR;
          state_next    = S_LF;
        end
      end
      S_LF: begin
        if (slot_free) begin
          res_load      = 1'b1;
          res.kind      = KIND_BYTE;
          res.data_byte = CHAR_LF;
          res.last      = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      rd_cnt  <= '0;
      fwd_ptr <= IDX_W'(3);
    end else if (state == S_ID) begin
      rd_cnt <= rd_cnt + 3'd1;
      // bytes 3..6 shift in from the top, one read behind the address
      if (rd_cnt != 3'd0) begin
        id_word <= {mem_rdata, id_word[31:8]};
      end
    end else if ((state == S_FOUT) && slot_free) begin
      fwd_ptr <= fwd_ptr + IDX_W'(1);
    end
  end

  lfpd_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .load       (res_load),
    .res        (res),
    .slot_free  (slot_free),
    .result_out (result_out)
  );

  a_open_matches_phase: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HEADER) == !packet_open)
    else $error("packet_open disagrees with parse phase");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    byte_index <= IDX_W'(BUF_DEPTH))
    else $error("byte index past buffer depth");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && (result_out.kind == KIND_ERROR)) |-> result_out.last)
    else $error("error result without last");

  a_no_input_while_busy: assert property (@(posedge clk) disable iff (rst)
    (res_load && (state != S_ERR) && (state != S_IDOUT) && !res.last) |=> !item_in.ready)
    else $error("input taken in the middle of a forward burst");

endmodule
